// ===== hw/rtl/gcr_pkg.sv =====
// Shared constants, types and helper functions of the grid ray cell walker.
package gcr_pkg;

  // Grid and output limits.
  localparam int MAX_CELLS_PER_SIDE = 256;
  localparam int MAX_CELLS_OUT      = 64;

  // Field widths of the ray and result transactions.
  localparam int POS_W     = 25;
  localparam int DIR_W     = 16;
  localparam int LEN_W     = 24;
  localparam int CS_W      = 13;
  localparam int CNTCFG_W  = 9;
  localparam int IDX_W     = 16;
  localparam int POS_FRAC  = 8;
  localparam int DIR_FRAC  = 14;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 2'd2;
  localparam logic [CS_W-1:0]      CELL_SIZE_RST    = 13'd128;
  localparam logic [CNTCFG_W-1:0]  CELLS_RST        = 9'd64;

  // Derived internal widths.
  localparam int CELL_W    = (MAX_CELLS_PER_SIDE > 1) ? $clog2(MAX_CELLS_PER_SIDE) : 1;
  localparam int CNT_W     = CELL_W + 1;
  localparam int OUT_CNT_W = $clog2(MAX_CELLS_OUT + 1);
  localparam int END_W     = POS_W + 2;
  localparam int PROD_W    = DIR_W + LEN_W + 1;
  localparam int ZC_W      = CNT_W + CS_W;
  localparam int LIN_W     = 32;
  localparam int DIV_W     = 48;
  localparam int DEN_W     = 24;
  localparam int DCNT_W    = $clog2(DIV_W + 1);
  localparam int CRD_W     = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CELL_W-1:0]        cell_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic signed [CRD_W-1:0]  coord_t;

  // Effective grid configuration seen by both halves.
  typedef struct packed {
    logic [CS_W-1:0] cs;
    count_t          nx;
    count_t          nz;
  } cfg_t;

  // Classified ray handed from the front to the back.
  typedef struct packed {
    logic                     single;
    logic                     up;
    logic                     lo_neg;
    logic                     lo_big;
    logic                     hi_neg;
    logic                     hi_big;
    cell_t                    zs;
    cell_t                    ze;
    cell_t                    xa;
    cell_t                    xb;
    logic signed [POS_W-1:0]  sx;
    logic signed [POS_W-1:0]  sz;
    logic signed [DIR_W-1:0]  dx;
    logic signed [DIR_W-1:0]  dz;
    logic [LEN_W-1:0]         len;
  } job_t;

  // Divider request and response.
  typedef struct packed {
    logic                     start;
    logic                     floor_mode;
    logic signed [DIV_W-1:0]  num;
    logic signed [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIV_W-1:0]  quo;
  } div_rsp_t;

  // Clamp a cell coordinate to [0, n - 1].
  function automatic cell_t clamp_cell(coord_t v, count_t n);
    coord_t top;
    cell_t  r;
    top = $signed({{(CRD_W-CNT_W){1'b0}}, n}) - coord_t'(1);
    if (v < 0) r = '0;
    else if (v > top) r = top[CELL_W-1:0];
    else r = v[CELL_W-1:0];
    return r;
  endfunction

  // Cell count with zero raised to one and large values saturated.
  function automatic count_t eff_count(logic [CNTCFG_W-1:0] c);
    logic [31:0] w;
    count_t      r;
    w = 32'(c);
    if (w == 32'd0) r = count_t'(1);
    else if (w > 32'(MAX_CELLS_PER_SIDE)) r = count_t'(MAX_CELLS_PER_SIDE);
    else r = count_t'(w);
    return r;
  endfunction

endpackage

// ===== hw/rtl/gcr_if.sv =====
// Channel interfaces of the grid ray cell walker: ray input, cell output, configuration.
interface gcr_ray_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gcr_pkg::POS_W-1:0]     start_x;
  logic signed [gcr_pkg::POS_W-1:0]     start_z;
  logic signed [gcr_pkg::DIR_W-1:0]     dir_x;
  logic signed [gcr_pkg::DIR_W-1:0]     dir_z;
  logic [gcr_pkg::LEN_W-1:0]            ray_length;
  modport source(output valid, start_x, start_z, dir_x, dir_z, ray_length, input ready);
  modport sink(input valid, start_x, start_z, dir_x, dir_z, ray_length, output ready);
endinterface

interface gcr_cell_if;
  logic                          valid;
  logic                          ready;
  logic [gcr_pkg::IDX_W-1:0]     cell_index;
  logic                          last_cell;
  logic                          truncated;
  modport source(output valid, cell_index, last_cell, truncated, input ready);
  modport sink(input valid, cell_index, last_cell, truncated, output ready);
endinterface

interface gcr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gcr_pkg::CFG_IDX_W-1:0]      index;
  logic [gcr_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gcr_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating or flooring.
module gcr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gcr_pkg::div_req_t req,
  output gcr_pkg::div_rsp_t rsp
);
  logic                              busy_r;
  logic                              done_r;
  logic [gcr_pkg::DCNT_W-1:0]        cnt_r;
  logic [gcr_pkg::DIV_W-1:0]         quo_r, quo_nxt;
  logic [gcr_pkg::DEN_W-1:0]         rem_r, rem_nxt;
  logic [gcr_pkg::DEN_W-1:0]         den_r;
  logic                              neg_q_r, neg_n_r, floor_r;
  logic [gcr_pkg::DIV_W-1:0]         num_mag;
  logic [gcr_pkg::DEN_W-1:0]         den_mag;
  logic [gcr_pkg::DEN_W:0]           shifted, diff;
  logic signed [gcr_pkg::DIV_W-1:0]  q_sgn;

  assign num_mag = req.num[gcr_pkg::DIV_W-1] ? gcr_pkg::DIV_W'(-req.num)
                                              : gcr_pkg::DIV_W'(req.num);
  assign den_mag = req.den[gcr_pkg::DEN_W-1] ? gcr_pkg::DEN_W'(-req.den)
                                              : gcr_pkg::DEN_W'(req.den);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem_r, quo_r[gcr_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, den_r};
    quo_nxt = {quo_r[gcr_pkg::DIV_W-2:0], ~diff[gcr_pkg::DEN_W]};
    rem_nxt = diff[gcr_pkg::DEN_W] ? shifted[gcr_pkg::DEN_W-1:0] : diff[gcr_pkg::DEN_W-1:0];
  end

  // Control: start, count the steps, pulse done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + gcr_pkg::DCNT_W'(1);
        if (cnt_r == gcr_pkg::DCNT_W'(gcr_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r   <= num_mag;
      rem_r   <= '0;
      den_r   <= den_mag;
      neg_n_r <= req.num[gcr_pkg::DIV_W-1];
      neg_q_r <= req.num[gcr_pkg::DIV_W-1] ^ req.den[gcr_pkg::DEN_W-1];
      floor_r <= req.floor_mode;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Sign fix, and a floor step for a negative dividend with a remainder.
  assign q_sgn    = neg_q_r ? -$signed(quo_r) : $signed(quo_r);
  assign rsp.done = done_r;
  assign rsp.quo  = (floor_r && neg_n_r && (rem_r != '0)) ? q_sgn - 1 : q_sgn;

endmodule

// ===== hw/rtl/gcr_front.sv =====
// Ray front end: accepts a ray, finds end point and end cells, classifies it.
module gcr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  gcr_pkg::cfg_t  cfg,
  gcr_ray_if.sink        in_ray,
  output logic           push_valid,
  input  logic           push_ready,
  output gcr_pkg::job_t  push_data
);
  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL  = 6'b000010,
    F_END  = 6'b000100,
    F_DGO  = 6'b001000,
    F_DWT  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t                            state_r, state_nxt;
  logic [1:0]                         idx_r, idx_nxt;
  logic signed [gcr_pkg::POS_W-1:0]   sx_r, sz_r;
  logic signed [gcr_pkg::DIR_W-1:0]   dx_r, dz_r;
  logic [gcr_pkg::LEN_W-1:0]          len_r;
  logic signed [gcr_pkg::PROD_W-1:0]  px_r, pz_r;
  logic signed [gcr_pkg::END_W-1:0]   tx_r, tz_r;
  gcr_pkg::coord_t                    crd_r [4];
  logic signed [gcr_pkg::END_W-1:0]   pos_sel;
  gcr_pkg::div_req_t                  dreq;
  gcr_pkg::div_rsp_t                  drsp;
  gcr_pkg::coord_t                    lo_c, hi_c, nz_c;

  gcr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ray.ready = (state_r == F_IDLE);
  assign push_valid   = (state_r == F_PUSH);

  // Sequencer: products, end point, four cell divisions, hand-off.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      F_IDLE: if (in_ray.valid) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_END;
      F_END: begin
        state_nxt = F_DGO;
        idx_nxt   = '0;
      end
      F_DGO:  state_nxt = F_DWT;
      F_DWT: begin
        if (drsp.done) begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd3) ? F_PUSH : F_DGO;
        end
      end
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Ray capture and end point arithmetic.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_ray.valid) begin
      sx_r  <= in_ray.start_x;
      sz_r  <= in_ray.start_z;
      dx_r  <= in_ray.dir_x;
      dz_r  <= in_ray.dir_z;
      len_r <= in_ray.ray_length;
    end
    if (state_r == F_MUL) begin
      px_r <= dx_r * $signed({1'b0, len_r});
      pz_r <= dz_r * $signed({1'b0, len_r});
    end
    if (state_r == F_END) begin
      tx_r <= gcr_pkg::END_W'(sx_r) + gcr_pkg::END_W'(px_r >>> gcr_pkg::DIR_FRAC);
      tz_r <= gcr_pkg::END_W'(sz_r) + gcr_pkg::END_W'(pz_r >>> gcr_pkg::DIR_FRAC);
    end
    if (state_r == F_DWT && drsp.done) begin
      crd_r[idx_r] <= drsp.quo[gcr_pkg::CRD_W-1:0];
    end
  end

  // Cell coordinate of start x, end x, start z, end z in turn.
  always_comb begin
    case (idx_r)
      2'd0:    pos_sel = gcr_pkg::END_W'(sx_r);
      2'd1:    pos_sel = tx_r;
      2'd2:    pos_sel = gcr_pkg::END_W'(sz_r);
      default: pos_sel = tz_r;
    endcase
  end

  assign dreq.start      = (state_r == F_DGO);
  assign dreq.floor_mode = 1'b1;
  assign dreq.num        = gcr_pkg::DIV_W'(pos_sel >>> gcr_pkg::POS_FRAC);
  assign dreq.den        = $signed({{(gcr_pkg::DEN_W-gcr_pkg::CS_W){1'b0}}, cfg.cs});

  // Classification of the ray into one row or a walk over rows.
  always_comb begin
    lo_c = (crd_r[2] < crd_r[3]) ? crd_r[2] : crd_r[3];
    hi_c = (crd_r[2] < crd_r[3]) ? crd_r[3] : crd_r[2];
    nz_c = $signed({{(gcr_pkg::CRD_W-gcr_pkg::CNT_W){1'b0}}, cfg.nz});
    push_data.single = (crd_r[2] == crd_r[3]);
    push_data.up     = (tz_r >= sz_r);
    push_data.lo_neg = (lo_c < 0);
    push_data.lo_big = (lo_c >= nz_c);
    push_data.hi_neg = (hi_c < 0);
    push_data.hi_big = (hi_c >= nz_c);
    push_data.zs     = gcr_pkg::clamp_cell(lo_c, cfg.nz);
    push_data.ze     = gcr_pkg::clamp_cell(hi_c, cfg.nz);
    push_data.xa     = gcr_pkg::clamp_cell(crd_r[0], cfg.nx);
    push_data.xb     = gcr_pkg::clamp_cell(crd_r[1], cfg.nx);
    push_data.sx     = sx_r;
    push_data.sz     = sz_r;
    push_data.dx     = dx_r;
    push_data.dz     = dz_r;
    push_data.len    = len_r;
  end

endmodule

// ===== hw/rtl/gcr_queue.sv =====
// Short queue of classified rays between the front end and the row walker.
module gcr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  gcr_pkg::job_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gcr_pkg::job_t  pop_data
);
  gcr_pkg::job_t                 mem [gcr_pkg::QUEUE_DEPTH];
  logic [gcr_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [gcr_pkg::QCNT_W-1:0]    cnt_r;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != gcr_pkg::QCNT_W'(gcr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == gcr_pkg::QPTR_W'(gcr_pkg::QUEUE_DEPTH - 1)) ? '0
                : wr_r + gcr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == gcr_pkg::QPTR_W'(gcr_pkg::QUEUE_DEPTH - 1)) ? '0
                : rd_r + gcr_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + gcr_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - gcr_pkg::QCNT_W'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/gcr_back.sv =====
// Row walker: computes each row's x span and sends its cells one per cycle while the output is not stalled.
module gcr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  gcr_pkg::cfg_t  cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  gcr_pkg::job_t  pop_data,
  gcr_cell_if.source     out_cell
);
  typedef enum logic [7:0] {
    B_IDLE = 8'b00000001,
    B_ZMUL = 8'b00000010,
    B_TGO  = 8'b00000100,
    B_TWT  = 8'b00001000,
    B_XMUL = 8'b00010000,
    B_XGO  = 8'b00100000,
    B_XWT  = 8'b01000000,
    B_EMIT = 8'b10000000
  } bstate_t;

  bstate_t                            state_r, state_nxt;
  gcr_pkg::job_t                      job_r;
  gcr_pkg::cell_t                     z_r, x_r, lo_r, hi_r, xa_r, xnew;
  logic                               k_r;
  logic [gcr_pkg::OUT_CNT_W-1:0]      cnt_r;
  logic [gcr_pkg::ZC_W-1:0]           zc_r;
  logic [gcr_pkg::LEN_W-1:0]          t_r, t_fix;
  logic signed [gcr_pkg::PROD_W-1:0]  pxm_r;
  logic                               out_valid_r, out_last_r, out_trunc_r;
  logic [gcr_pkg::IDX_W-1:0]          out_idx_r;
  gcr_pkg::count_t                    bnd;
  logic signed [gcr_pkg::DIV_W-1:0]   bpos, tnum, xpos, len48;
  logic                               ovr, oval_len;
  logic                               can_load, end_all, at_lim, last_nxt;
  logic [gcr_pkg::LIN_W-1:0]          lin;
  gcr_pkg::div_req_t                  dreq;
  gcr_pkg::div_rsp_t                  drsp;

  gcr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign pop_ready = (state_r == B_IDLE);

  // Boundary z of the current row edge, and the ray parameter there.
  assign bnd   = {1'b0, z_r} + gcr_pkg::count_t'(k_r);
  assign bpos  = $signed({{(gcr_pkg::DIV_W-gcr_pkg::ZC_W-gcr_pkg::POS_FRAC){1'b0}},
                          zc_r, {gcr_pkg::POS_FRAC{1'b0}}});
  assign tnum  = (bpos - gcr_pkg::DIV_W'(job_r.sz)) <<< gcr_pkg::DIR_FRAC;
  assign xpos  = gcr_pkg::DIV_W'(job_r.sx) + gcr_pkg::DIV_W'(pxm_r >>> gcr_pkg::DIR_FRAC);
  assign len48 = $signed({{(gcr_pkg::DIV_W-gcr_pkg::LEN_W){1'b0}}, job_r.len});

  // Divider use: parameter at the row edge, then x cell at that parameter.
  always_comb begin
    dreq.start      = (state_r == B_TGO) || (state_r == B_XGO);
    dreq.floor_mode = (state_r == B_XGO);
    if (state_r == B_XGO) begin
      dreq.num = xpos >>> gcr_pkg::POS_FRAC;
      dreq.den = $signed({{(gcr_pkg::DEN_W-gcr_pkg::CS_W){1'b0}}, cfg.cs});
    end else begin
      dreq.num = tnum;
      dreq.den = gcr_pkg::DEN_W'(job_r.dz);
    end
  end

  // Out-of-map ends take the exact parameter of that ray end; others clamp.
  always_comb begin
    if (k_r) begin
      ovr = (job_r.hi_neg && (z_r == '0)) || (job_r.hi_big && (z_r == job_r.ze));
      oval_len = job_r.up;
    end else begin
      ovr = (job_r.lo_neg && (z_r == '0)) || (job_r.lo_big && (z_r == job_r.ze));
      oval_len = !job_r.up;
    end
    if (ovr) t_fix = oval_len ? job_r.len : '0;
    else if (drsp.quo < 0) t_fix = '0;
    else if (drsp.quo > len48) t_fix = job_r.len;
    else t_fix = drsp.quo[gcr_pkg::LEN_W-1:0];
    xnew = gcr_pkg::clamp_cell(drsp.quo[gcr_pkg::CRD_W-1:0], cfg.nx);
  end

  // Emission of the current cell into the output register.
  assign can_load = !out_valid_r || out_cell.ready;
  assign end_all  = (x_r == hi_r) && (z_r == job_r.ze);
  assign at_lim   = (cnt_r == gcr_pkg::OUT_CNT_W'(gcr_pkg::MAX_CELLS_OUT - 1));
  assign last_nxt = end_all || at_lim;
  assign lin      = gcr_pkg::LIN_W'(z_r) * gcr_pkg::LIN_W'(cfg.nx) + gcr_pkg::LIN_W'(x_r);

  // Sequencer over rows and the lower and upper edge of each row.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) state_nxt = pop_data.single ? B_EMIT : B_ZMUL;
      B_ZMUL: state_nxt = B_TGO;
      B_TGO:  state_nxt = B_TWT;
      B_TWT:  if (drsp.done) state_nxt = B_XMUL;
      B_XMUL: state_nxt = B_XGO;
      B_XGO:  state_nxt = B_XWT;
      B_XWT:  if (drsp.done) state_nxt = k_r ? B_EMIT : B_ZMUL;
      B_EMIT: begin
        if (can_load) begin
          if (last_nxt) state_nxt = B_IDLE;
          else if (x_r == hi_r) state_nxt = B_ZMUL;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_EMIT && can_load) out_valid_r <= 1'b1;
      else if (out_cell.ready) out_valid_r <= 1'b0;
    end
  end

  // Walk datapath.
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      job_r <= pop_data;
      z_r   <= pop_data.zs;
      k_r   <= 1'b0;
      cnt_r <= '0;
      lo_r  <= (pop_data.xa <= pop_data.xb) ? pop_data.xa : pop_data.xb;
      hi_r  <= (pop_data.xa <= pop_data.xb) ? pop_data.xb : pop_data.xa;
      x_r   <= (pop_data.xa <= pop_data.xb) ? pop_data.xa : pop_data.xb;
    end
    if (state_r == B_ZMUL) zc_r <= gcr_pkg::ZC_W'(bnd) * gcr_pkg::ZC_W'(cfg.cs);
    if (state_r == B_TWT && drsp.done) t_r <= t_fix;
    if (state_r == B_XMUL) pxm_r <= job_r.dx * $signed({1'b0, t_r});
    if (state_r == B_XWT && drsp.done) begin
      if (k_r) begin
        lo_r <= (xa_r <= xnew) ? xa_r : xnew;
        hi_r <= (xa_r <= xnew) ? xnew : xa_r;
        x_r  <= (xa_r <= xnew) ? xa_r : xnew;
        k_r  <= 1'b0;
      end else begin
        xa_r <= xnew;
        k_r  <= 1'b1;
      end
    end
    if (state_r == B_EMIT && can_load) begin
      out_idx_r   <= lin[gcr_pkg::IDX_W-1:0];
      out_last_r  <= last_nxt;
      out_trunc_r <= at_lim && !end_all;
      cnt_r       <= cnt_r + gcr_pkg::OUT_CNT_W'(1);
      if (x_r == hi_r) z_r <= z_r + gcr_pkg::cell_t'(1);
      else x_r <= x_r + gcr_pkg::cell_t'(1);
    end
  end

  assign out_cell.valid      = out_valid_r;
  assign out_cell.cell_index = out_idx_r;
  assign out_cell.last_cell  = out_last_r;
  assign out_cell.truncated  = out_trunc_r;

endmodule

// ===== hw/rtl/grid_cells_on_ray.sv =====
// Top level of the grid ray cell walker: configuration, front end, queue, row walker.
//
//   channel   direction  handshake      payload
//   in_ray    in         valid/ready    start_x, start_z, dir_x, dir_z, ray_length
//   out_cell  out        valid/ready    cell_index, last_cell, truncated
//   cfg_wr    in         valid/ready    index, data (ready is always high)
//
// Every division runs on a one-bit-per-cycle divider of 48 steps.
// The front end does four cell divisions per ray and then hands the ray on through a
// two-entry queue, so it takes the next ray while the walker works.
// A ray in one row goes straight to emission in the walker; a walked ray takes two parameter
// and two x divisions per row, then sends the row's cells one per cycle unless stalled.
// Reset is synchronous; output stalls hold the walker, and the front end once the queue is full.
module grid_cells_on_ray (
  input  logic        clk,
  input  logic        rst_n,
  gcr_ray_if.sink     in_ray,
  gcr_cell_if.source  out_cell,
  gcr_cfg_if.sink     cfg_wr
);
  logic [gcr_pkg::CS_W-1:0]      cs_r;
  logic [gcr_pkg::CNTCFG_W-1:0]  nx_r, nz_r;
  gcr_pkg::cfg_t                 cfg;
  logic                          q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  gcr_pkg::job_t                 q_push_data, q_pop_data;

  assign cfg_wr.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= gcr_pkg::CELL_SIZE_RST;
      nx_r <= gcr_pkg::CELLS_RST;
      nz_r <= gcr_pkg::CELLS_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        gcr_pkg::REG_CELL_SIZE:    cs_r <= cfg_wr.data;
        gcr_pkg::REG_CELLS_ACROSS: nx_r <= cfg_wr.data[gcr_pkg::CNTCFG_W-1:0];
        gcr_pkg::REG_CELLS_DOWN:   nz_r <= cfg_wr.data[gcr_pkg::CNTCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid settings: zero size and counts act as one, counts saturate.
  assign cfg.cs = (cs_r == '0) ? gcr_pkg::CS_W'(1) : cs_r;
  assign cfg.nx = gcr_pkg::eff_count(nx_r);
  assign cfg.nz = gcr_pkg::eff_count(nz_r);

  gcr_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_ray(in_ray),
    .push_valid(q_push_valid), .push_ready(q_push_ready), .push_data(q_push_data)
  );

  gcr_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(q_push_valid), .push_ready(q_push_ready), .push_data(q_push_data),
    .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_data(q_pop_data)
  );

  gcr_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_data(q_pop_data),
    .out_cell(out_cell)
  );

endmodule

// ===== hw/rtl/gcr_checker.sv =====
// Port-level checks of the grid ray cell walker, bound to the top level.
module gcr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gcr_pkg::IDX_W-1:0]  out_index,
  input logic                       out_last,
  input logic                       out_trunc
);

  // A stalled cell transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_last)
      && $stable(out_trunc))
    else $error("cell transaction changed while stalled");

  // The truncated mark only appears on the final cell of a ray.
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trunc |-> out_last)
    else $error("truncated without last_cell");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind grid_cells_on_ray gcr_checker u_gcr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_cell.valid),
  .out_ready(out_cell.ready),
  .out_index(out_cell.cell_index),
  .out_last(out_cell.last_cell),
  .out_trunc(out_cell.truncated)
);

// ===== tb/grid_cells_on_ray_test.sv =====
// Self-checking testbench of grid_cells_on_ray: rays in, predicted cell indices checked out.

// One ray transaction as driven on the input channel.
typedef struct {
  logic signed [gcr_pkg::POS_W-1:0] sx;
  logic signed [gcr_pkg::POS_W-1:0] sz;
  logic signed [gcr_pkg::DIR_W-1:0] dx;
  logic signed [gcr_pkg::DIR_W-1:0] dz;
  logic [gcr_pkg::LEN_W-1:0]        len;
} ray_t;

// One cell transaction as seen on the output channel.
typedef struct {
  logic [gcr_pkg::IDX_W-1:0] idx;
  logic                      last;
  logic                      trunc;
} cell_rec_t;

// Computes the cells each accepted ray covers and checks the block's cells in order.
class cell_walk_board;
  logic [gcr_pkg::CS_W-1:0]     cell_size;
  logic [gcr_pkg::CNTCFG_W-1:0] cells_across;
  logic [gcr_pkg::CNTCFG_W-1:0] cells_down;
  cell_rec_t                    pending_cells[$];
  cell_rec_t                    ray_cells[$];
  bit                           dropped;
  int                           errors;
  int                           rays_seen;
  int                           cells_seen;
  int                           truncs_seen;

  function new();
    cell_size    = gcr_pkg::CELL_SIZE_RST;
    cells_across = gcr_pkg::CELLS_RST;
    cells_down   = gcr_pkg::CELLS_RST;
    errors = 0;
    rays_seen = 0;
    cells_seen = 0;
    truncs_seen = 0;
  endfunction

  function void write_reg(logic [gcr_pkg::CFG_IDX_W-1:0] idx,
                          logic [gcr_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      gcr_pkg::REG_CELL_SIZE:    cell_size    = data[gcr_pkg::CS_W-1:0];
      gcr_pkg::REG_CELLS_ACROSS: cells_across = data[gcr_pkg::CNTCFG_W-1:0];
      gcr_pkg::REG_CELLS_DOWN:   cells_down   = data[gcr_pkg::CNTCFG_W-1:0];
      default: ;
    endcase
  endfunction

  function longint grid_count(logic [gcr_pkg::CNTCFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > gcr_pkg::MAX_CELLS_PER_SIDE) return gcr_pkg::MAX_CELLS_PER_SIDE;
    return longint'(c);
  endfunction

  function longint cell_span();
    return (cell_size == 0 ? 64'd1 : longint'(cell_size)) * 256;
  endfunction

  function longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Appends one row's x span, lowest x first, up to the output limit.
  function void add_span(longint row, longint a, longint b, longint nx);
    longint t;
    cell_rec_t c;
    if (b < a) begin
      t = a;
      a = b;
      b = t;
    end
    for (longint x = a; x <= b; x++) begin
      if (ray_cells.size() >= gcr_pkg::MAX_CELLS_OUT) begin
        dropped = 1;
        return;
      end
      c.idx = gcr_pkg::IDX_W'(row * nx + x);
      c.last = 0;
      c.trunc = 0;
      ray_cells.insert(ray_cells.size(), c);
    end
  endfunction

  // Notes an accepted ray and queues the cells it must produce.
  function void note_ray(ray_t r);
    longint sx, sz, dx, dz, len, csq, nx, nz, tx, tz;
    longint cxs, cxt, czs, czt, lo, hi, zs, ze, t0, t1, x0, x1;
    bit up;
    sx = longint'(r.sx);
    sz = longint'(r.sz);
    dx = longint'(r.dx);
    dz = longint'(r.dz);
    len = longint'(r.len);
    csq = cell_span();
    nx = grid_count(cells_across);
    nz = grid_count(cells_down);
    tx = sx + fdiv(dx * len, 16384);
    tz = sz + fdiv(dz * len, 16384);
    cxs = fdiv(sx, csq);
    cxt = fdiv(tx, csq);
    czs = fdiv(sz, csq);
    czt = fdiv(tz, csq);
    ray_cells.delete();
    dropped = 0;
    rays_seen++;
    if (czs == czt) begin
      add_span(clampl(czs, 0, nz - 1), clampl(cxs, 0, nx - 1), clampl(cxt, 0, nx - 1), nx);
    end else if (dz != 0) begin
      // Walk every touched row, fixing the parameters of ends outside the map.
      up = tz >= sz;
      lo = czs < czt ? czs : czt;
      hi = czs < czt ? czt : czs;
      zs = clampl(lo, 0, nz - 1);
      ze = clampl(hi, 0, nz - 1);
      for (longint z = zs; z <= ze && !dropped; z++) begin
        t0 = ((z * csq - sz) * 16384) / dz;
        t1 = (((z + 1) * csq - sz) * 16384) / dz;
        if ((lo < 0 && z == 0) || (lo >= nz && z == ze)) t0 = up ? 0 : len;
        if ((hi < 0 && z == 0) || (hi >= nz && z == ze)) t1 = up ? len : 0;
        t0 = clampl(t0, 0, len);
        t1 = clampl(t1, 0, len);
        x0 = fdiv(sx + fdiv(dx * t0, 16384), csq);
        x1 = fdiv(sx + fdiv(dx * t1, 16384), csq);
        add_span(z, clampl(x0, 0, nx - 1), clampl(x1, 0, nx - 1), nx);
      end
    end
    if (ray_cells.size() > 0) begin
      ray_cells[$].last = 1;
      ray_cells[$].trunc = dropped;
    end
    foreach (ray_cells[i]) pending_cells.insert(pending_cells.size(), ray_cells[i]);
  endfunction

  // Checks one cell transaction against the oldest pending cell.
  function void check_cell(cell_rec_t got);
    cell_rec_t want;
    cells_seen++;
    if (got.trunc) truncs_seen++;
    if (pending_cells.size() == 0) begin
      $display("%0t: unexpected cell idx=%0d last=%0b trunc=%0b",
               $time, got.idx, got.last, got.trunc);
      errors++;
      return;
    end
    want = pending_cells.pop_front();
    if (got.idx !== want.idx)
      $display("%0t: cell_index expected %0d actual %0d", $time, want.idx, got.idx);
    if (got.last !== want.last)
      $display("%0t: last_cell expected %0b actual %0b", $time, want.last, got.last);
    if (got.trunc !== want.trunc)
      $display("%0t: truncated expected %0b actual %0b", $time, want.trunc, got.trunc);
    if (got.idx !== want.idx || got.last !== want.last || got.trunc !== want.trunc)
      errors++;
  endfunction
endclass

module grid_cells_on_ray_test;
  localparam int IDLE_LIMIT = 40000;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_cycles;
  int   quiet_cycles;

  cell_walk_board board;

  gcr_ray_if  ray_ch();
  gcr_cell_if cell_ch();
  gcr_cfg_if  cfg_ch();

  grid_cells_on_ray u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ray   (ray_ch.sink),
    .out_cell (cell_ch.source),
    .cfg_wr   (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        cell_ch.ready = 0;
        hold_cycles--;
      end else begin
        cell_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Output monitor and the idle watchdog.
  always @(posedge clk) begin
    cell_rec_t got;
    if (rst_n && cell_ch.valid && cell_ch.ready) begin
      got.idx = cell_ch.cell_index;
      got.last = cell_ch.last_cell;
      got.trunc = cell_ch.truncated;
      board.check_cell(got);
    end
    if ((ray_ch.valid && ray_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("grid_cells_on_ray verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [gcr_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_ch.valid = 1;
    cfg_ch.index = idx;
    cfg_ch.data = gcr_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, gcr_pkg::CFG_DATA_W'(value));
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      ray_ch.valid = 0;
    end
    @(negedge clk);
    ray_ch.valid = 1;
    ray_ch.start_x = r.sx;
    ray_ch.start_z = r.sz;
    ray_ch.dir_x = r.dx;
    ray_ch.dir_z = r.dz;
    ray_ch.ray_length = r.len;
    do @(posedge clk); while (!ray_ch.ready);
    board.note_ray(r);
  endtask

  task automatic send_directed(longint sx, longint sz, int dx, int dz, longint len);
    ray_t r;
    r.sx = gcr_pkg::POS_W'(sx);
    r.sz = gcr_pkg::POS_W'(sz);
    r.dx = gcr_pkg::DIR_W'(dx);
    r.dz = gcr_pkg::DIR_W'(dz);
    r.len = gcr_pkg::LEN_W'(len);
    send_ray(r);
  endtask

  // Lowers valid and waits until every pending cell has come out, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    ray_ch.valid = 0;
    while (board.pending_cells.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_grid(int cs, int nx, int nz);
    write_reg(gcr_pkg::REG_CELL_SIZE, cs);
    write_reg(gcr_pkg::REG_CELLS_ACROSS, nx);
    write_reg(gcr_pkg::REG_CELLS_DOWN, nz);
  endtask

  function automatic longint fit_pos(longint v);
    return v < -16777216 ? -16777216 : (v > 16777215 ? 16777215 : v);
  endfunction

  // Random ray: mostly near the map with short lengths, some fully random.
  function automatic ray_t rand_ray();
    ray_t   r;
    longint csq, wx, wz, lmax;
    csq = board.cell_span();
    wx = board.grid_count(board.cells_across) * csq + 2 * csq;
    wz = board.grid_count(board.cells_down) * csq + 2 * csq;
    if ($urandom_range(99) < 12) begin
      r.sx = gcr_pkg::POS_W'($urandom);
      r.sz = gcr_pkg::POS_W'($urandom);
    end else begin
      r.sx = gcr_pkg::POS_W'(fit_pos(-csq + longint'($urandom_range(0, 32'(wx)))));
      r.sz = gcr_pkg::POS_W'(fit_pos(-csq + longint'($urandom_range(0, 32'(wz)))));
    end
    case ($urandom_range(0, 9))
      0: begin
        r.dx = gcr_pkg::DIR_W'($urandom_range(1) ? 16384 : -16384);
        r.dz = '0;
      end
      1: begin
        r.dx = '0;
        r.dz = gcr_pkg::DIR_W'($urandom_range(1) ? 16384 : -16384);
      end
      default: begin
        r.dx = gcr_pkg::DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        r.dz = gcr_pkg::DIR_W'(int'($urandom_range(0, 32768)) - 16384);
      end
    endcase
    lmax = 3 * csq > 16777215 ? 16777215 : 3 * csq;
    if ($urandom_range(99) < 12) r.len = gcr_pkg::LEN_W'($urandom);
    else r.len = gcr_pkg::LEN_W'($urandom_range(0, 32'(lmax)));
    return r;
  endfunction

  task automatic random_rays(int n);
    repeat (n) send_ray(rand_ray());
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    board = new();
    ray_ch.valid = 0;
    ray_ch.start_x = '0;
    ray_ch.start_z = '0;
    ray_ch.dir_x = '0;
    ray_ch.dir_z = '0;
    ray_ch.ray_length = '0;
    cell_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = gcr_pkg::REG_CELL_SIZE;
    cfg_ch.data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // Directed rays on the reset grid: 128-unit cells, 64 by 64.
    send_directed(100, 100, 16384, 0, 10);
    send_directed(40000, 70000, 5000, -3000, 0);
    send_directed(1000, 1000, 16384, 0, 20 * 32768);
    send_directed(1500000, 40000, -16384, 0, 30 * 32768);
    send_directed(5000, 5000, 0, 16384, 5 * 32768);
    send_directed(5000, 5000, 11585, 11585, 8 * 32768);
    send_directed(2000000, 2000000, -11585, -11585, 10 * 32768);
    // Lower end below the map, higher end past the map, and a downward ray from outside.
    send_directed(50000, -100000, 0, 16384, 10 * 32768);
    send_directed(50000, 2000000, 3000, 16384, 10 * 32768);
    send_directed(50000, 2200000, 5000, -16384, 10 * 32768);
    send_directed(100000, -300000, -4000, 16384, 2200000);
    // Exactly the cell limit in one row, then a ray that overruns it.
    send_directed(0, 0, 16384, 0, 64 * 32768);
    send_directed(0, 0, 11585, 11585, 16777215);
    send_directed(0, 300000, 16384, 700, 16777215);
    // Extremes of every field.
    send_directed(-16777216, -16777216, -16384, -16384, 16777215);
    send_directed(16777215, 16777215, 16384, 16384, 16777215);
    send_directed(-16777216, 16777215, 16384, -16384, 16777215);
    send_directed(300000, 300000, 0, 0, 16777215);
    send_directed(300000, 300000, 1, 16384, 4 * 32768);
    send_directed(300000, 300000, -1, -16384, 4 * 32768);
    drain();

    // Smallest grid, sender mostly idle.
    set_grid(1, 1, 1);
    send_idle_pct = 86;
    random_rays(14);
    drain();

    // Largest legal grid, receiver mostly stalled.
    set_grid(4096, 256, 256);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    random_rays(14);
    drain();

    // Zero size and counts behave as one; both sides idle now and then.
    set_grid(0, 0, 0);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    random_rays(10);
    drain();

    // Register maxima for size and cells across: both counts saturate at the grid limit.
    set_grid(8191, 511, 300);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_rays(10);
    drain();

    // Small grid with a long output hold-off so the input backs up.
    set_grid(16, 20, 12);
    hold_cycles = 1500;
    random_rays(14);
    drain();
    send_idle_pct = 13;
    recv_stall_pct = 13;
    random_rays(14);
    drain();

    $display("covered %0d rays and %0d cells (%0d truncated) over six grid settings",
             board.rays_seen, board.cells_seen, board.truncs_seen);
    $display("with directed edge rays, random idling, stalls and a long output hold-off");
    if (board.errors == 0 && board.pending_cells.size() == 0) begin
      $display("grid_cells_on_ray verification clean");
    end else begin
      $display("grid_cells_on_ray verification failed");
    end
    $finish;
  end
endmodule
